>>> rtl/core/plst_pkg.sv
// Shared types and constants for the positional list store.
`default_nettype none

package plst_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int POS_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_READ   = 3'd3,
        ACT_FIND   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_STEP,
        S_PUT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        action;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data_out;
        logic [POS_W-1:0]  found_at;
        logic [CNT_W-1:0]  count;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [POS_W-1:0]  raddr;
    } t_ram_req;

endpackage

`default_nettype wire

>>> rtl/core/plst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module plst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/plst_ctrl.sv
// Command sequencer: walks the list one entry per step for shift, read and search.
`default_nettype none

module plst_ctrl import plst_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    input  wire t_cmd              i_cmd,
    output logic                   o_ready,
    input  wire logic              i_res_ready,
    output logic                   o_done,
    output t_res                   o_res,
    output t_ram_req               o_ram,
    input  wire logic [DATA_W-1:0] i_rdata
);

    t_state            r_state, n_state;
    t_action           r_act;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_value;
    logic [POS_W-1:0]  r_idx, n_idx;
    logic              r_first, n_first;
    logic [CNT_W-1:0]  r_used, n_used;
    logic              r_ok, n_ok;
    logic [DATA_W-1:0] r_data, n_data;
    logic [POS_W-1:0]  r_found, n_found;

    logic              accept;
    logic              full;
    logic              pos_in_range;
    logic              more_left;
    t_action           in_act;

    assign accept       = i_cmd_valid && (r_state == S_IDLE);
    assign full         = (r_used == CNT_W'(DEPTH));
    assign pos_in_range = (CNT_W'(i_cmd.position) < r_used);
    assign more_left    = ((CNT_W'(r_idx) + CNT_W'(1)) < r_used);
    assign in_act       = t_action'(i_cmd.action);

    // Next state and datapath register updates.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_first = r_first;
        n_used  = r_used;
        n_ok    = r_ok;
        n_data  = r_data;
        n_found = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ok    = 1'b0;
                    n_data  = '0;
                    n_found = '0;
                    n_first = 1'b1;
                    n_state = S_DONE;
                    unique case (in_act)
                        ACT_APPEND: begin
                            if (!full) begin
                                n_used = r_used + CNT_W'(1);
                                n_ok   = 1'b1;
                            end
                        end
                        ACT_INSERT: begin
                            if (r_used != '0 && pos_in_range && !full) begin
                                n_idx   = POS_W'(r_used - CNT_W'(1));
                                n_state = S_READ;
                            end
                        end
                        ACT_REMOVE, ACT_READ: begin
                            if (pos_in_range) begin
                                n_idx   = i_cmd.position;
                                n_state = S_READ;
                            end
                        end
                        ACT_FIND: begin
                            if (r_used != '0) begin
                                n_idx   = '0;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                n_first = 1'b0;
                n_state = S_DONE;
                unique case (r_act)
                    ACT_INSERT: begin
                        // The word just moved up came from the insert point.
                        if (r_idx == r_pos) begin
                            n_state = S_PUT;
                        end else begin
                            n_idx   = r_idx - POS_W'(1);
                            n_state = S_READ;
                        end
                    end
                    ACT_REMOVE: begin
                        if (r_first) begin
                            n_data = i_rdata;
                        end
                        if (more_left) begin
                            n_idx   = r_idx + POS_W'(1);
                            n_state = S_READ;
                        end else begin
                            n_used = r_used - CNT_W'(1);
                            n_ok   = 1'b1;
                        end
                    end
                    ACT_READ: begin
                        n_data = i_rdata;
                        n_ok   = 1'b1;
                    end
                    ACT_FIND: begin
                        if (i_rdata == r_value) begin
                            n_ok    = 1'b1;
                            n_found = r_idx;
                        end else if (more_left) begin
                            n_idx   = r_idx + POS_W'(1);
                            n_state = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PUT: begin
                n_used  = r_used + CNT_W'(1);
                n_ok    = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory port and handshake outputs.
    always_comb begin
        o_ram.we    = 1'b0;
        o_ram.waddr = r_idx;
        o_ram.wdata = r_value;
        o_ram.raddr = r_idx;
        o_ready     = 1'b0;
        o_done      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (accept && in_act == ACT_APPEND && !full) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = POS_W'(r_used);
                    o_ram.wdata = i_cmd.value;
                end
            end
            S_READ: begin
                o_ram.we = 1'b0;
            end
            S_STEP: begin
                if (r_act == ACT_INSERT) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_idx + POS_W'(1);
                    o_ram.wdata = i_rdata;
                end else if (r_act == ACT_REMOVE && !r_first) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_idx - POS_W'(1);
                    o_ram.wdata = i_rdata;
                end
            end
            S_PUT: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_pos;
                o_ram.wdata = r_value;
            end
            S_DONE: begin
                o_done = i_res_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign o_res.ok       = r_ok;
    assign o_res.data_out = r_data;
    assign o_res.found_at = r_found;
    assign o_res.count    = r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= in_act;
            r_pos   <= i_cmd.position;
            r_value <= i_cmd.value;
        end
        r_idx   <= n_idx;
        r_ok    <= n_ok;
        r_data  <= n_data;
        r_found <= n_found;
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == $past(r_used)) || (r_used == $past(r_used) + CNT_W'(1))
        || (r_used + CNT_W'(1) == $past(r_used)))
        else $error("entry count moved by more than one");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_DONE) |-> !o_ram.we)
        else $error("memory written outside a write step");

    a_read_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_act == ACT_READ) |=> (r_state == S_DONE))
        else $error("read command did not finish after one step");

endmodule

`default_nettype wire

>>> rtl/core/positional_list_store_core.sv
// Top level of the positional list store: sequencer, entry memory and result register.
// Commands go from S_IDLE to S_DONE and then into the result register. Append and failing
// commands go straight to S_DONE; read, find, insert and remove pass S_READ then S_STEP per
// entry visited, insert then S_PUT; the first remove step fetches the removed word. One
// command runs at a time; each entry step reads in S_READ and, for insert and remove, writes
// the moved word in S_STEP. Reset clears the entry count and control; words are not cleared.
`default_nettype none

module positional_list_store_core import plst_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    input  wire t_cmd i_cmd,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              done;
    t_res              seq_res;
    logic              res_room;
    logic              r_res_valid;
    t_res              r_res;

    // The result register frees the sequencer while a word waits downstream.
    assign res_room = !r_res_valid || i_res_ready;

    plst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .i_cmd       (i_cmd),
        .o_ready     (o_cmd_ready),
        .i_res_ready (res_room),
        .o_done      (done),
        .o_res       (seq_res),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    plst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (done) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_res <= seq_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire
